>>> sv/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    // frame delimiter and control byte of a sequence-zero data frame
    localparam logic [7:0] FLAG_BYTE        = 8'h7e;
    localparam logic [7:0] SEQ_ZERO_CONTROL = 8'h00;

    // payload limit and the counter that tracks it
    localparam int MAX_PAYLOAD = 512;
    localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

    // result field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUFF_MASK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_ONE_CONTROL = 2'd2;

    // register reset values
    localparam logic [7:0] ESCAPE_BYTE_RESET     = 8'h7d;
    localparam logic [7:0] STUFF_MASK_RESET      = 8'h20;
    localparam logic [7:0] SEQ_ONE_CONTROL_RESET = 8'h40;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_CTRL,
        PH_HCHK,
        PH_BODY,
        PH_DROP
    } phase_t;

    // result kind
    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0,
        K_COMMAND = 3'd1,
        K_GOOD    = 3'd2,
        K_DUP     = 3'd3,
        K_ERROR   = 3'd4
    } kind_t;

endpackage

`default_nettype wire

>>> sv/sfr_byte_if.sv
`default_nettype none

interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> sv/sfr_result_if.sv
`default_nettype none

interface sfr_result_if;
    logic                           valid;
    logic                           ready;
    sfr_pkg::kind_t                 kind;
    logic [sfr_pkg::BYTE_W-1:0]     value;
    logic [sfr_pkg::BYTE_W-1:0]     address;
    logic [sfr_pkg::LEN_W-1:0]      length;

    modport source (output valid, output kind, output value, output address,
                    output length, input ready);
    modport sink   (input valid, input kind, input value, input address,
                    input length, output ready);
endinterface

`default_nettype wire

>>> sv/sfr_cfg_if.sv
`default_nettype none

interface sfr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sfr_pkg::CFG_IDX_W-1:0]     index;
    logic [7:0]                        wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> sv/stuffed_frame_receiver_unit.sv
// Byte stuffed frame receiver.
// rx carries one received serial byte per beat. res carries parsed results:
// destuffed payload bytes (kind payload), command frames, and the frame-end
// outcome (good, duplicate / out of sequence, error) with the control byte,
// address and payload length. cfg writes escape_byte, stuff_mask and
// seq_one_control by index; it is always ready and should only be used
// while the block is idle.
// Throughput: one byte per cycle. Every byte is parsed in the cycle it is
// accepted against the frame state registers; a result appears on res the
// cycle after its triggering byte is accepted, in one output register.
// Stall: rx.ready stays high while the output register is empty or being
// taken in the same cycle; while a result waits on a low res.ready, rx.ready
// is low and no byte is lost.
// Reset: the parser hunts for an opening flag, the expected sequence bit is
// zero, the output register is empty and the registers take their default
// values (escape 0x7d, mask 0x20, sequence-one control 0x40).
`default_nettype none

module stuffed_frame_receiver_unit (
    input  wire              clk,
    input  wire              rst_n,
    sfr_byte_if.sink         rx,
    sfr_result_if.source     res,
    sfr_cfg_if.sink          cfg
);

    localparam int CW = sfr_pkg::COUNT_W;

    // configuration registers
    logic [7:0] escape_byte_reg;
    logic [7:0] stuff_mask_reg;
    logic [7:0] seq_one_control_reg;

    // frame state
    sfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      address_reg, address_next;
    logic [7:0]      control_reg, control_next;
    logic            esc_pend_reg, esc_pend_next;
    logic [7:0]      held_byte_reg, held_byte_next;
    logic            held_valid_reg, held_valid_next;
    logic [7:0]      check_reg, check_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            exp_seq_reg, exp_seq_next;

    // output register
    logic                    res_valid_reg, res_valid_next;
    sfr_pkg::kind_t          res_kind_reg, res_kind_next;
    logic [7:0]              res_value_reg, res_value_next;
    logic [7:0]              res_address_reg, res_address_next;
    logic [sfr_pkg::LEN_W-1:0] res_length_reg, res_length_next;
    logic                    emit;

    // byte decode
    logic       rx_accept;
    logic       is_flag;
    logic       in_seq;
    logic       have_d;
    logic [7:0] d_byte;
    logic       at_limit;
    logic       is_command;
    logic       end_bad;

    assign rx.ready  = !res_valid_reg || res.ready;
    assign rx_accept = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign is_flag  = (rx.rx_byte == sfr_pkg::FLAG_BYTE);
    assign in_seq   = (control_reg == (exp_seq_reg ? seq_one_control_reg
                                                   : sfr_pkg::SEQ_ZERO_CONTROL));
    assign at_limit = (count_reg >= CW'(sfr_pkg::MAX_PAYLOAD));
    assign is_command = (count_reg == '0) && !held_valid_reg && !esc_pend_reg;
    assign end_bad  = esc_pend_reg || !held_valid_reg || (held_byte_reg != check_reg);

    // destuffing: an escape is swallowed, the byte after it is unmasked
    assign have_d = esc_pend_reg || (rx.rx_byte != escape_byte_reg);
    assign d_byte = esc_pend_reg ? (rx.rx_byte ^ stuff_mask_reg) : rx.rx_byte;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (rx_accept)
        begin
            case (phase_reg)
                sfr_pkg::PH_HUNT:
                begin
                    if (is_flag)
                        phase_next = sfr_pkg::PH_ADDR;
                end
                sfr_pkg::PH_ADDR:
                begin
                    if (!is_flag)
                        phase_next = sfr_pkg::PH_CTRL;
                end
                sfr_pkg::PH_CTRL:
                    phase_next = sfr_pkg::PH_HCHK;
                sfr_pkg::PH_HCHK:
                begin
                    if (rx.rx_byte == (address_reg ^ control_reg))
                        phase_next = sfr_pkg::PH_BODY;
                    else
                        phase_next = sfr_pkg::PH_HUNT;
                end
                sfr_pkg::PH_BODY:
                begin
                    if (is_flag)
                        phase_next = sfr_pkg::PH_ADDR;
                    else if (have_d && held_valid_reg && at_limit)
                        phase_next = sfr_pkg::PH_DROP;
                end
                sfr_pkg::PH_DROP:
                begin
                    if (is_flag)
                        phase_next = sfr_pkg::PH_ADDR;
                end
                default:
                    phase_next = sfr_pkg::PH_HUNT;
            endcase
        end
    end

    // frame datapath and result selection
    always_comb
    begin
        address_next    = address_reg;
        control_next    = control_reg;
        esc_pend_next   = esc_pend_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        check_next      = check_reg;
        count_next      = count_reg;
        exp_seq_next    = exp_seq_reg;
        emit            = 1'b0;
        res_kind_next   = res_kind_reg;
        res_value_next  = res_value_reg;
        res_length_next = res_length_reg;
        if (rx_accept)
        begin
            case (phase_reg)
                sfr_pkg::PH_ADDR:
                begin
                    if (!is_flag)
                        address_next = rx.rx_byte;
                end
                sfr_pkg::PH_CTRL:
                    control_next = rx.rx_byte;
                sfr_pkg::PH_HCHK:
                begin
                    if (rx.rx_byte == (address_reg ^ control_reg))
                    begin
                        esc_pend_next   = 1'b0;
                        held_valid_next = 1'b0;
                        held_byte_next  = '0;
                        check_next      = '0;
                        count_next      = '0;
                    end
                end
                sfr_pkg::PH_BODY:
                begin
                    if (is_flag)
                    begin
                        emit            = 1'b1;
                        res_value_next  = control_reg;
                        res_length_next = sfr_pkg::LEN_W'(count_reg);
                        if (is_command)
                        begin
                            res_kind_next   = sfr_pkg::K_COMMAND;
                            res_length_next = '0;
                        end
                        else if (!in_seq)
                            res_kind_next = sfr_pkg::K_DUP;
                        else if (end_bad)
                            res_kind_next = sfr_pkg::K_ERROR;
                        else
                        begin
                            res_kind_next = sfr_pkg::K_GOOD;
                            exp_seq_next  = !exp_seq_reg;
                        end
                    end
                    else if (!have_d)
                        esc_pend_next = 1'b1;
                    else
                    begin
                        esc_pend_next = 1'b0;
                        if (!held_valid_reg)
                        begin
                            held_byte_next  = d_byte;
                            held_valid_next = 1'b1;
                        end
                        else if (!at_limit)
                        begin
                            // commit the held byte, hold the new one back
                            count_next     = count_reg + CW'(1);
                            check_next     = check_reg ^ held_byte_reg;
                            held_byte_next = d_byte;
                            if (in_seq)
                            begin
                                emit            = 1'b1;
                                res_kind_next   = sfr_pkg::K_PAYLOAD;
                                res_value_next  = held_byte_reg;
                                res_length_next = '0;
                            end
                        end
                    end
                end
                sfr_pkg::PH_DROP:
                begin
                    if (is_flag)
                    begin
                        emit            = 1'b1;
                        res_value_next  = control_reg;
                        res_length_next = sfr_pkg::LEN_W'(count_reg);
                        if (!in_seq)
                            res_kind_next = sfr_pkg::K_DUP;
                        else
                            res_kind_next = sfr_pkg::K_ERROR;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register handshake
    assign res_address_next = emit ? address_reg : res_address_reg;
    assign res_valid_next   = emit || (res_valid_reg && !res.ready);

    assign res.valid   = res_valid_reg;
    assign res.kind    = res_kind_reg;
    assign res.value   = res_value_reg;
    assign res.address = res_address_reg;
    assign res.length  = res_length_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_byte_reg     <= sfr_pkg::ESCAPE_BYTE_RESET;
            stuff_mask_reg      <= sfr_pkg::STUFF_MASK_RESET;
            seq_one_control_reg <= sfr_pkg::SEQ_ONE_CONTROL_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                sfr_pkg::CFG_ESCAPE_BYTE:     escape_byte_reg     <= cfg.wdata;
                sfr_pkg::CFG_STUFF_MASK:      stuff_mask_reg      <= cfg.wdata;
                sfr_pkg::CFG_SEQ_ONE_CONTROL: seq_one_control_reg <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    // frame state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sfr_pkg::PH_HUNT;
            address_reg    <= '0;
            control_reg    <= '0;
            esc_pend_reg   <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            check_reg      <= '0;
            count_reg      <= '0;
            exp_seq_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            address_reg    <= address_next;
            control_reg    <= control_next;
            esc_pend_reg   <= esc_pend_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            check_reg      <= check_next;
            count_reg      <= count_next;
            exp_seq_reg    <= exp_seq_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_kind_reg    <= res_kind_next;
        res_value_reg   <= res_value_next;
        res_address_reg <= res_address_next;
        res_length_reg  <= res_length_next;
    end

    // a flag in the body always ends the frame with a result
    a_flag_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && is_flag && phase_reg == sfr_pkg::PH_BODY |=> res_valid_reg)
        else $error("flag in body gave no result");

    // the payload counter never passes the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(sfr_pkg::MAX_PAYLOAD))
        else $error("payload count above limit");

    // dropping only happens once the limit is reached with a byte held
    a_drop_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sfr_pkg::PH_DROP |-> held_valid_reg && at_limit)
        else $error("drop phase without full payload");

    // a byte is never taken while a stalled result sits in the register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !rx_accept)
        else $error("byte accepted over stalled result");

endmodule

`default_nettype wire
